@@ hw/rtl/ssd_pkg.sv @@
// Shared types, constants and glyph decode for the seven-segment scan driver.
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

	// Glyph table size and the number of glyph codes in use.
	localparam int GLYPH_COUNT = 45;
	localparam int TABLE_LEN   = 45;

	// Scan and blink timing.
	localparam logic [2:0]  SCAN_DIGITS      = 3'd4;
	localparam logic [7:0]  DIM_DARK_LEVEL   = 8'd250;
	localparam logic [12:0] FLICKER_DIVIDE   = 13'd18;
	localparam logic [12:0] FLASH_ON_TICKS   = 13'd2000;
	localparam logic [12:0] FLASH_PERIOD     = 13'd5000;
	localparam logic [6:0]  ZOOM_TOP         = 7'd80;
	localparam logic [5:0]  ZOOM_PRESCALE    = 6'd50;

	// Beeper burst cadence.
	localparam logic [13:0] BEEP_ON_0   = 14'd1;
	localparam logic [13:0] BEEP_ON_1   = 14'd2001;
	localparam logic [13:0] BEEP_ON_2   = 14'd4001;
	localparam logic [13:0] BEEP_ON_3   = 14'd6001;
	localparam logic [13:0] BEEP_OFF_0  = 14'd500;
	localparam logic [13:0] BEEP_OFF_1  = 14'd2500;
	localparam logic [13:0] BEEP_OFF_2  = 14'd4500;
	localparam logic [13:0] BEEP_OFF_3  = 14'd6500;
	localparam logic [13:0] BEEP_PERIOD = 14'd15000;

	// Digit code fields.
	localparam logic [7:0] CODE_GLYPH_MASK = 8'h3F;
	localparam logic [7:0] CODE_DP_BIT     = 8'h80;
	localparam logic [7:0] SEG_DP          = 8'h10;
	localparam logic [7:0] BLANK_CODE      = 8'h0A;

	// Display modes.
	localparam logic [2:0] MODE_BRIGHT      = 3'd0;
	localparam logic [2:0] MODE_DIM         = 3'd1;
	localparam logic [2:0] MODE_FLICKER     = 3'd2;
	localparam logic [2:0] MODE_DIM_FLICKER = 3'd3;
	localparam logic [2:0] MODE_OFF         = 3'd4;
	localparam logic [2:0] MODE_FLASH       = 3'd5;
	localparam logic [2:0] MODE_ZOOM        = 3'd6;

	// Beeper modes.
	localparam logic [1:0] BEEP_MODE_OFF   = 2'd0;
	localparam logic [1:0] BEEP_MODE_BURST = 2'd1;
	localparam logic [1:0] BEEP_MODE_ON    = 2'd2;

	// Item kinds.
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_DIM_LEVEL       = 2'd0;
	localparam logic [1:0] CFG_BRIGHT_LEVEL    = 2'd1;
	localparam logic [1:0] CFG_INVERT_POLARITY = 2'd2;

	// Segment patterns, active high: A=0x04 B=0x08 C=0x20 D=0x40 E=0x80 F=0x02 G=0x01.
	localparam logic [7:0] GLYPH_ROM [TABLE_LEN] = '{
		8'hEE, 8'h28, 8'hCD, 8'h6D, 8'h2B, 8'h67, 8'hE7, 8'h2C, 8'hEF, 8'h6F,
		8'h00, 8'hC6, 8'h01, 8'hC2, 8'hE3, 8'hE9, 8'hE1, 8'hC7, 8'h40, 8'h87,
		8'hAF, 8'h82, 8'hC3, 8'h8F, 8'hA4, 8'h6B, 8'hA1, 8'h81, 8'h4A, 8'hAB,
		8'hEA, 8'hE0, 8'h00, 8'h40, 8'h20, 8'h60, 8'h08, 8'h48, 8'h28, 8'h68,
		8'h04, 8'h44, 8'h01, 8'h01, 8'h01
	};

	typedef struct packed {
		logic       kind;
		logic [7:0] digit_code_0;
		logic [7:0] digit_code_1;
		logic [7:0] digit_code_2;
		logic [7:0] digit_code_3;
		logic [2:0] display_mode;
		logic       colon_enable;
		logic [1:0] buzzer_mode;
	} in_item_t;

	typedef struct packed {
		logic [7:0] segment_lines;
		logic [3:0] digit_enables;
		logic       colon_pin;
		logic       beeper_pin;
		logic       scan_sync;
	} out_item_t;

	typedef struct packed {
		logic [7:0] dim_level;
		logic [7:0] bright_level;
		logic       invert_polarity;
	} cfg_t;

	typedef struct packed {
		logic [7:0] segment_lines;
		logic [3:0] digit_enables;
		logic       colon_pin;
		logic       scan_sync;
	} disp_t;

	// Segment port byte for one digit code, after polarity.
	function automatic logic [7:0] slot_pattern(input logic [7:0] code, input logic invert);
		logic [5:0] idx;
		logic [7:0] pat;
		idx = code[5:0];
		pat = 8'h00;
		if ((32'(idx) < GLYPH_COUNT) && (32'(idx) < TABLE_LEN)) begin
			pat = GLYPH_ROM[idx];
		end
		if ((code & CODE_DP_BIT) != 8'h00) begin
			pat = pat | SEG_DP;
		end
		return invert ? ~pat : pat;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/seven_segment_scan_driver_core.sv @@
// Top level of the seven-segment scan driver: input register, config registers, result register.
// A tick transferred in is held in the input register, then registered in the result register,
// from which it transfers out once the output does not stall.
// Throughput: one item per cycle unless the output stalls; a load gives no result, a tick one.
// The input register and the result register bound a single pass of counter logic.
// Reset: arst_n clears all counters, blanks the latched digits and sets the config defaults.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_scan_driver_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ssd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ssd_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import ssd_pkg::*;

	cfg_t      cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	logic      advance;
	logic      tick;
	logic      load;
	disp_t     disp_next;
	logic      beeper_next;
	out_item_t out_q;
	logic      out_valid_q;

	// Configuration registers take every write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_level       <= 8'd40;
			cfg_q.bright_level    <= 8'd0;
			cfg_q.invert_polarity <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DIM_LEVEL:       cfg_q.dim_level       <= cfg_data;
				CFG_BRIGHT_LEVEL:    cfg_q.bright_level    <= cfg_data;
				CFG_INVERT_POLARITY: cfg_q.invert_polarity <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// The held item moves on when it is a load or the result register has room.
	assign advance  = valid_s1 && ((item_s1.kind == KIND_LOAD) || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign tick     = advance && (item_s1.kind == KIND_TICK);
	assign load     = advance && (item_s1.kind == KIND_LOAD);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	ssd_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.load      (load),
		.item      (item_s1),
		.cfg       (cfg_q),
		.disp_next (disp_next)
	);

	ssd_beeper u_beeper (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick),
		.load        (load),
		.buzzer_mode (item_s1.buzzer_mode),
		.beeper_next (beeper_next)
	);

	// Result register: filled by a tick, emptied by a transfer out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			out_q.segment_lines <= disp_next.segment_lines;
			out_q.digit_enables <= disp_next.digit_enables;
			out_q.colon_pin     <= disp_next.colon_pin;
			out_q.beeper_pin    <= beeper_next;
			out_q.scan_sync     <= disp_next.scan_sync;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A stall toward the input only comes from a full result register held by the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	// Every tick that leaves the input register lands in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> out_valid_q)
		else $error("tick did not produce a result");

	// A load never creates a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(load && !out_valid_q) |=> !out_valid_q)
		else $error("load produced a result");

endmodule

`default_nettype wire

@@ hw/rtl/ssd_beeper.sv @@
// Beeper mode latch, burst cadence counter and beeper pin level.
`timescale 1ns / 1ps
`default_nettype none

module ssd_beeper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tick,
	input  logic       load,
	input  logic [1:0] buzzer_mode,
	output logic       beeper_next
);
	import ssd_pkg::*;

	logic [1:0]  active_q;
	logic [13:0] count_q;
	logic [13:0] count_next;
	logic [13:0] count_inc;
	logic        beeper_q;

	assign count_inc = count_q + 14'd1;

	// Next beeper level and cadence count for a tick.
	always_comb begin
		beeper_next = beeper_q;
		count_next  = count_q;
		if (tick) begin
			case (active_q)
				BEEP_MODE_OFF: begin
					beeper_next = 1'b0;
					count_next  = '0;
				end
				BEEP_MODE_ON: begin
					beeper_next = 1'b1;
					count_next  = '0;
				end
				BEEP_MODE_BURST: begin
					count_next = count_inc;
					if (count_inc == BEEP_ON_0 || count_inc == BEEP_ON_1 ||
					    count_inc == BEEP_ON_2 || count_inc == BEEP_ON_3) begin
						beeper_next = 1'b1;
					end else if (count_inc == BEEP_OFF_0 || count_inc == BEEP_OFF_1 ||
					             count_inc == BEEP_OFF_2 || count_inc == BEEP_OFF_3) begin
						beeper_next = 1'b0;
					end else if (count_inc == BEEP_PERIOD) begin
						count_next = '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Mode latch, counter and pin level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= BEEP_MODE_OFF;
			count_q  <= '0;
			beeper_q <= 1'b0;
		end else begin
			if (load) begin
				active_q <= buzzer_mode;
			end
			count_q  <= count_next;
			beeper_q <= beeper_next;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ssd_scan.sv @@
// Digit scan, brightness blanking, blink and zoom counters and display pin levels.
`timescale 1ns / 1ps
`default_nettype none

module ssd_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick,
	input  logic             load,
	input  ssd_pkg::in_item_t item,
	input  ssd_pkg::cfg_t     cfg,
	output ssd_pkg::disp_t    disp_next
);
	import ssd_pkg::*;

	// Counters.
	logic [2:0]  scan_index_q, scan_index_n;
	logic [8:0]  blank_count_q, blank_count_n;
	logic [12:0] blink_count_q, blink_count_n;
	logic [6:0]  zoom_level_q, zoom_level_n;
	logic [5:0]  zoom_prescale_q, zoom_prescale_n;
	logic        zoom_falling_q, zoom_falling_n;

	// Latched display content.
	logic [7:0]  shown_q [4];
	logic [2:0]  mode_q;
	logic        colon_q;

	// Pin levels held between rewrites.
	logic [7:0]  seg_q, seg_n;
	logic [3:0]  en_q, en_n;
	logic        colon_hold_q, colon_hold_n;
	logic        sync_n;

	// Slot decode shared by all scanning modes.
	logic [1:0]  slot;
	logic [7:0]  slot_seg;
	logic [3:0]  slot_bit;
	logic [3:0]  dark_en;
	logic [3:0]  lit_en;
	logic        slot_colon;
	logic        in_digits;
	logic [8:0]  blank_inc;
	logic [12:0] blink_inc;
	logic [5:0]  prescale_inc;
	logic [6:0]  zoom_up;
	logic [6:0]  zoom_down;

	// Scan control chosen by the mode.
	logic        do_scan;
	logic        light;
	logic [8:0]  level;

	assign slot         = scan_index_q[1:0];
	assign slot_seg     = slot_pattern(shown_q[slot], cfg.invert_polarity);
	assign slot_bit     = 4'b0001 << slot;
	assign dark_en      = cfg.invert_polarity ? 4'h0 : 4'hF;
	assign lit_en       = cfg.invert_polarity ? slot_bit : ~slot_bit;
	assign slot_colon   = (slot == 2'd0) && colon_q;
	assign in_digits    = scan_index_q < SCAN_DIGITS;
	assign blank_inc    = blank_count_q + 9'd1;
	assign blink_inc    = blink_count_q + 13'd1;
	assign prescale_inc = zoom_prescale_q + 6'd1;
	assign zoom_up      = zoom_level_q + 7'd1;
	assign zoom_down    = zoom_level_q - 7'd1;

	// Next counter and pin state for a tick.
	always_comb begin
		scan_index_n    = scan_index_q;
		blank_count_n   = blank_count_q;
		blink_count_n   = blink_count_q;
		zoom_level_n    = zoom_level_q;
		zoom_prescale_n = zoom_prescale_q;
		zoom_falling_n  = zoom_falling_q;
		seg_n           = seg_q;
		en_n            = en_q;
		colon_hold_n    = colon_hold_q;
		sync_n          = 1'b0;
		do_scan         = 1'b0;
		light           = 1'b1;
		level           = '0;

		if (tick) begin
			case (mode_q)
				MODE_BRIGHT: begin
					do_scan = 1'b1;
					level   = {1'b0, cfg.bright_level};
				end
				MODE_DIM: begin
					do_scan = 1'b1;
					level   = {1'b0, cfg.dim_level};
					light   = cfg.dim_level < DIM_DARK_LEVEL;
				end
				MODE_FLICKER, MODE_DIM_FLICKER: begin
					level = (mode_q == MODE_FLICKER) ? {1'b0, cfg.bright_level}
					                                 : {1'b0, cfg.dim_level};
					if (blink_count_q > FLICKER_DIVIDE) begin
						do_scan       = 1'b1;
						blink_count_n = '0;
					end else begin
						blink_count_n = blink_inc;
					end
				end
				MODE_OFF: begin
					en_n         = dark_en;
					colon_hold_n = 1'b0;
				end
				MODE_FLASH: begin
					en_n         = dark_en;
					colon_hold_n = 1'b0;
					if (blink_count_q < FLASH_ON_TICKS) begin
						if (in_digits) begin
							seg_n        = slot_seg;
							en_n         = lit_en;
							colon_hold_n = slot_colon;
							scan_index_n = scan_index_q + 3'd1;
						end else begin
							scan_index_n = '0;
						end
					end
					sync_n        = 1'b1;
					blink_count_n = (blink_inc > FLASH_PERIOD) ? 13'd0 : blink_inc;
				end
				MODE_ZOOM: begin
					do_scan = 1'b1;
					level   = {2'b00, zoom_level_q};
					// The zoom sweep steps only on blank slots.
					if (!in_digits) begin
						zoom_prescale_n = prescale_inc;
						if (prescale_inc >= ZOOM_PRESCALE) begin
							zoom_prescale_n = '0;
							if (!zoom_falling_q) begin
								zoom_level_n = zoom_up;
								if (zoom_up >= ZOOM_TOP) begin
									zoom_falling_n = 1'b1;
								end
							end else begin
								zoom_level_n = zoom_down;
								if (zoom_down == 7'd0) begin
									zoom_falling_n = 1'b0;
								end
							end
						end
					end
				end
				default: begin
				end
			endcase

			// One step of the scan: a digit slot or a blank slot.
			if (do_scan) begin
				en_n         = dark_en;
				colon_hold_n = 1'b0;
				if (in_digits) begin
					seg_n        = slot_seg;
					scan_index_n = scan_index_q + 3'd1;
					if (light) begin
						en_n         = lit_en;
						colon_hold_n = slot_colon;
					end
				end else begin
					sync_n        = 1'b1;
					blank_count_n = blank_inc;
					if (blank_inc > level) begin
						scan_index_n  = '0;
						blank_count_n = '0;
					end
				end
			end
		end
	end

	assign disp_next.segment_lines = seg_n;
	assign disp_next.digit_enables = en_n;
	assign disp_next.colon_pin     = colon_hold_n;
	assign disp_next.scan_sync     = sync_n;

	// Counter and pin state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_index_q    <= '0;
			blank_count_q   <= '0;
			blink_count_q   <= '0;
			zoom_level_q    <= '0;
			zoom_prescale_q <= '0;
			zoom_falling_q  <= 1'b0;
			seg_q           <= 8'hFF;
			en_q            <= 4'hF;
			colon_hold_q    <= 1'b0;
		end else begin
			scan_index_q    <= scan_index_n;
			blank_count_q   <= blank_count_n;
			blink_count_q   <= blink_count_n;
			zoom_level_q    <= zoom_level_n;
			zoom_prescale_q <= zoom_prescale_n;
			zoom_falling_q  <= zoom_falling_n;
			seg_q           <= seg_n;
			en_q            <= en_n;
			colon_hold_q    <= colon_hold_n;
		end
	end

	// Display content latched by a load; it takes effect from the next tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q[0] <= BLANK_CODE;
			shown_q[1] <= BLANK_CODE;
			shown_q[2] <= BLANK_CODE;
			shown_q[3] <= BLANK_CODE;
			mode_q     <= MODE_BRIGHT;
			colon_q    <= 1'b0;
		end else if (load) begin
			shown_q[0] <= item.digit_code_0;
			shown_q[1] <= item.digit_code_1;
			shown_q[2] <= item.digit_code_2;
			shown_q[3] <= item.digit_code_3;
			mode_q     <= item.display_mode;
			colon_q    <= item.colon_enable;
		end
	end

endmodule

`default_nettype wire

@@ dv/seven_segment_scan_driver_core_tb.sv @@
// Self-checking testbench for the seven-segment scan driver core: scripted and random transfers.
`timescale 1ns / 1ps

module seven_segment_scan_driver_core_tb;
	import ssd_pkg::*;

	// Segment bits of the display port, active high.
	localparam logic [7:0] SEG_A     = 8'h04;
	localparam logic [7:0] SEG_B     = 8'h08;
	localparam logic [7:0] SEG_C     = 8'h20;
	localparam logic [7:0] SEG_D     = 8'h40;
	localparam logic [7:0] SEG_E     = 8'h80;
	localparam logic [7:0] SEG_F     = 8'h02;
	localparam logic [7:0] SEG_G     = 8'h01;
	localparam logic [7:0] SEG_POINT = 8'h10;
	localparam int GLYPH_TOTAL = 45;

	localparam logic [7:0] GLYPHS [GLYPH_TOTAL] = '{
		SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F, SEG_B | SEG_C,
		SEG_A | SEG_B | SEG_D | SEG_E | SEG_G, SEG_A | SEG_B | SEG_C | SEG_D | SEG_G,
		SEG_G | SEG_B | SEG_C | SEG_F, SEG_A | SEG_G | SEG_C | SEG_D | SEG_F,
		SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G, SEG_A | SEG_B | SEG_C,
		SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G,
		SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G,
		8'h00, SEG_A | SEG_D | SEG_E | SEG_F, SEG_G, SEG_F | SEG_E | SEG_D,
		SEG_C | SEG_D | SEG_E | SEG_F | SEG_G, SEG_G | SEG_B | SEG_E | SEG_C | SEG_D,
		SEG_G | SEG_C | SEG_D | SEG_E, SEG_A | SEG_F | SEG_G | SEG_E | SEG_D,
		SEG_D, SEG_A | SEG_F | SEG_G | SEG_E, SEG_A | SEG_B | SEG_C | SEG_E | SEG_F | SEG_G,
		SEG_F | SEG_E, SEG_F | SEG_E | SEG_G | SEG_D, SEG_A | SEG_B | SEG_E | SEG_F | SEG_G,
		SEG_E | SEG_C | SEG_A, SEG_B | SEG_C | SEG_D | SEG_F | SEG_G,
		SEG_C | SEG_E | SEG_G, SEG_E | SEG_G, SEG_F | SEG_B | SEG_D,
		SEG_B | SEG_C | SEG_E | SEG_F | SEG_G, SEG_B | SEG_C | SEG_D | SEG_E | SEG_F,
		SEG_C | SEG_E | SEG_D,
		8'h00, SEG_D, SEG_C, SEG_D | SEG_C, SEG_B, SEG_B | SEG_D, SEG_B | SEG_C,
		SEG_B | SEG_D | SEG_C, SEG_A, SEG_A | SEG_D, SEG_G, SEG_G, SEG_G
	};

	// Timing of the display and beeper counters.
	localparam logic [7:0]  DIM_DARK     = 8'd250;
	localparam logic [12:0] FLICKER_LAST = 13'd18;
	localparam logic [12:0] FLASH_LIT    = 13'd2000;
	localparam logic [12:0] FLASH_LAST   = 13'd5000;
	localparam logic [6:0]  ZOOM_PEAK    = 7'd80;
	localparam logic [5:0]  ZOOM_DIV     = 6'd50;
	localparam logic [13:0] BURST_ON_A   = 14'd1;
	localparam logic [13:0] BURST_ON_B   = 14'd2001;
	localparam logic [13:0] BURST_ON_C   = 14'd4001;
	localparam logic [13:0] BURST_ON_D   = 14'd6001;
	localparam logic [13:0] BURST_OFF_A  = 14'd500;
	localparam logic [13:0] BURST_OFF_B  = 14'd2500;
	localparam logic [13:0] BURST_OFF_C  = 14'd4500;
	localparam logic [13:0] BURST_OFF_D  = 14'd6500;
	localparam logic [13:0] BURST_WRAP   = 14'd15000;

	// Codes the package leaves unnamed.
	localparam logic [2:0] MODE_UNUSED      = 3'd7;
	localparam logic [1:0] BEEP_MODE_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

	// Run shape.
	localparam int ITEM_BITS     = $bits(in_item_t);
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 120;
	localparam int FLASH_SOAK    = 150;
	localparam int ZOOM_SOAK     = 150;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_LIMIT   = 10000;
	localparam int MAX_REPORTS   = 30;

	typedef struct packed {
		in_item_t  item;
		logic      typed;
		out_item_t want;
	} script_row_t;

	localparam in_item_t  TICK_ITEM = {KIND_TICK, 38'h0};
	localparam out_item_t NO_CHECK  = '0;
	localparam int SCRIPT_LEN = 25;

	// Opening script: known values after reset, glyph extremes and every mode.
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{item: TICK_ITEM, typed: 1'b1, want: '{segment_lines: 8'hFF, digit_enables: 4'h1,
			colon_pin: 1'b0, beeper_pin: 1'b0, scan_sync: 1'b0}},
		'{item: {KIND_LOAD, 8'h0A, 8'h0A, 8'h0A, 8'h0A, MODE_OFF, 1'b0, BEEP_MODE_ON},
			typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b1, want: '{segment_lines: 8'hFF, digit_enables: 4'h0,
			colon_pin: 1'b0, beeper_pin: 1'b1, scan_sync: 1'b0}},
		'{item: {KIND_LOAD, 8'hBF, 8'h2C, 8'h2D, 8'h48, MODE_BRIGHT, 1'b1, BEEP_MODE_BURST},
			typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK},
		'{item: {KIND_LOAD, 8'h00, 8'hFF, 8'h7F, 8'h89, MODE_DIM, 1'b1, BEEP_MODE_BURST},
			typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK},
		'{item: {KIND_LOAD, 8'h00, 8'hFF, 8'h7F, 8'h89, MODE_FLICKER, 1'b0, BEEP_MODE_OFF},
			typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK},
		'{item: {KIND_LOAD, 8'h00, 8'hFF, 8'h7F, 8'h89, MODE_DIM_FLICKER, 1'b1, BEEP_MODE_ON},
			typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK},
		'{item: {KIND_LOAD, 8'h00, 8'hFF, 8'h7F, 8'h89, MODE_FLASH, 1'b1, BEEP_MODE_BURST},
			typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK},
		'{item: {KIND_LOAD, 8'h00, 8'hFF, 8'h7F, 8'h89, MODE_ZOOM, 1'b0, BEEP_MODE_BURST},
			typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK},
		'{item: {KIND_LOAD, 8'h00, 8'hFF, 8'h7F, 8'h89, MODE_UNUSED, 1'b1, BEEP_MODE_UNUSED},
			typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK},
		'{item: {KIND_LOAD, 8'h00, 8'hFF, 8'h7F, 8'h89, MODE_BRIGHT, 1'b1, BEEP_MODE_OFF},
			typed: 1'b0, want: NO_CHECK},
		'{item: TICK_ITEM, typed: 1'b0, want: NO_CHECK}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	// Predicted display state and register copies.
	logic [7:0]  dim_lvl, bright_lvl;
	logic        invert;
	logic [2:0]  scan_idx;
	logic [8:0]  blank_cnt;
	logic [12:0] blink_cnt;
	logic [13:0] beep_cnt;
	logic [6:0]  zoom_lvl;
	logic [5:0]  zoom_pre;
	logic        zoom_down;
	logic [7:0]  digits [4];
	logic [2:0]  disp_mode;
	logic        colon_en;
	logic [1:0]  beep_mode;
	logic [7:0]  seg_q;
	logic [3:0]  en_q;
	logic        colon_q, beep_q, sync_q;

	out_item_t pin_levels_q [$];
	out_item_t expected_pins;
	int        fail_count = 0;
	int        burst_left = 0;
	int        stall_left = 0;
	int        stall_phase = 0;
	logic [1:0] stall_style = '0;

	seven_segment_scan_driver_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// All digit selects and the colon go dark.
	function automatic void darken();
		en_q = invert ? 4'h0 : 4'hF;
		colon_q = 1'b0;
	endfunction

	// Put one digit on the segment port and optionally light its select.
	function automatic void show_digit(input logic [1:0] d, input logic light);
		logic [7:0] code;
		logic [7:0] pat;
		code = digits[d];
		pat = (int'(code[5:0]) < GLYPH_TOTAL) ? GLYPHS[code[5:0]] : 8'h00;
		if (code[7]) begin
			pat = pat | SEG_POINT;
		end
		seg_q = invert ? ~pat : pat;
		if (light) begin
			en_q[d] = invert;
			if (d == 2'd0 && colon_en) begin
				colon_q = 1'b1;
			end
		end
	endfunction

	// One scan slot; returns 1 when the slot was a blank one.
	function automatic logic scan_slot(input logic [8:0] level, input logic light);
		darken();
		if (scan_idx < 3'd4) begin
			show_digit(scan_idx[1:0], light);
			scan_idx = scan_idx + 3'd1;
			return 1'b0;
		end
		sync_q = 1'b1;
		blank_cnt = blank_cnt + 9'd1;
		if (blank_cnt > level) begin
			scan_idx = '0;
			blank_cnt = '0;
		end
		return 1'b1;
	endfunction

	// Flicker modes scan on every 20th tick only.
	function automatic void flicker_step(input logic [8:0] level);
		if (blink_cnt > FLICKER_LAST) begin
			void'(scan_slot(level, 1'b1));
			blink_cnt = '0;
		end else begin
			blink_cnt = blink_cnt + 13'd1;
		end
	endfunction

	// Advance the predicted display by one transfer; returns 1 when a result follows.
	function automatic logic step_display(input in_item_t it, output out_item_t r);
		r = '0;
		if (it.kind == KIND_LOAD) begin
			digits[0] = it.digit_code_0;
			digits[1] = it.digit_code_1;
			digits[2] = it.digit_code_2;
			digits[3] = it.digit_code_3;
			disp_mode = it.display_mode;
			colon_en = it.colon_enable;
			beep_mode = it.buzzer_mode;
			return 1'b0;
		end
		sync_q = 1'b0;

		// Beeper cadence.
		case (beep_mode)
			BEEP_MODE_OFF: begin
				beep_q = 1'b0;
				beep_cnt = '0;
			end
			BEEP_MODE_ON: begin
				beep_q = 1'b1;
				beep_cnt = '0;
			end
			BEEP_MODE_BURST: begin
				beep_cnt = beep_cnt + 14'd1;
				case (beep_cnt)
					BURST_ON_A, BURST_ON_B, BURST_ON_C, BURST_ON_D: beep_q = 1'b1;
					BURST_OFF_A, BURST_OFF_B, BURST_OFF_C, BURST_OFF_D: beep_q = 1'b0;
					BURST_WRAP: beep_cnt = '0;
					default: ;
				endcase
			end
			default: ;
		endcase

		// Display modes.
		case (disp_mode)
			MODE_BRIGHT: void'(scan_slot({1'b0, bright_lvl}, 1'b1));
			MODE_DIM: void'(scan_slot({1'b0, dim_lvl}, dim_lvl < DIM_DARK));
			MODE_FLICKER: flicker_step({1'b0, bright_lvl});
			MODE_DIM_FLICKER: flicker_step({1'b0, dim_lvl});
			MODE_OFF: darken();
			MODE_FLASH: begin
				darken();
				if (blink_cnt < FLASH_LIT) begin
					if (scan_idx < 3'd4) begin
						show_digit(scan_idx[1:0], 1'b1);
						scan_idx = scan_idx + 3'd1;
					end else begin
						scan_idx = '0;
					end
				end
				sync_q = 1'b1;
				blink_cnt = blink_cnt + 13'd1;
				if (blink_cnt > FLASH_LAST) begin
					blink_cnt = '0;
				end
			end
			MODE_ZOOM: begin
				if (scan_slot({2'b00, zoom_lvl}, 1'b1)) begin
					zoom_pre = zoom_pre + 6'd1;
					if (zoom_pre >= ZOOM_DIV) begin
						zoom_pre = '0;
						if (!zoom_down) begin
							zoom_lvl = zoom_lvl + 7'd1;
							if (zoom_lvl >= ZOOM_PEAK) begin
								zoom_down = 1'b1;
							end
						end else begin
							zoom_lvl = zoom_lvl - 7'd1;
							if (zoom_lvl == 7'd0) begin
								zoom_down = 1'b0;
							end
						end
					end
				end
			end
			default: ;
		endcase

		r.segment_lines = seg_q;
		r.digit_enables = en_q;
		r.colon_pin = colon_q;
		r.beeper_pin = beep_q;
		r.scan_sync = sync_q;
		return 1'b1;
	endfunction

	// Digit code: mostly a valid glyph, otherwise any byte; top bits always random.
	function automatic logic [7:0] random_code();
		logic [7:0] code;
		code = 8'($urandom);
		if ($urandom_range(0, 2) != 0) begin
			code[5:0] = 6'($urandom_range(0, GLYPH_TOTAL - 1));
		end
		return code;
	endfunction

	function automatic in_item_t random_load();
		in_item_t it;
		it = in_item_t'(ITEM_BITS'({$urandom, $urandom}));
		it.kind = KIND_LOAD;
		it.digit_code_0 = random_code();
		it.digit_code_1 = random_code();
		it.digit_code_2 = random_code();
		it.digit_code_3 = random_code();
		it.display_mode = ($urandom_range(0, 15) == 0) ? MODE_UNUSED : 3'($urandom_range(0, 6));
		it.buzzer_mode = ($urandom_range(0, 15) == 0) ? BEEP_MODE_UNUSED
			: 2'($urandom_range(0, 2));
		return it;
	endfunction

	// A tick carries random content in the fields it does not use.
	function automatic in_item_t random_tick();
		in_item_t it;
		it = in_item_t'(ITEM_BITS'({$urandom, $urandom}));
		it.kind = KIND_TICK;
		return it;
	endfunction

	// Send one item in bursts with random gaps; predict its result on transfer.
	task automatic send_item(input in_item_t it, input logic typed, input out_item_t typed_val);
		out_item_t predicted;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? 300 : int'($urandom_range(1, 40));
			@(negedge clk) in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		if (step_display(it, predicted)) begin
			pin_levels_q.push_back(typed ? typed_val : predicted);
		end
	endtask

	// Hold the sender until every expected result has come, then let the block settle.
	task automatic drain_results();
		int waited;
		waited = 0;
		@(negedge clk) in_valid <= 1'b0;
		while (pin_levels_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pin_levels_q.size() != 0) begin
			fail_count++;
			$display("%0t ns: %0d expected results never arrived", $time, pin_levels_q.size());
			pin_levels_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_DIM_LEVEL: dim_lvl = val;
			CFG_BRIGHT_LEVEL: bright_lvl = val;
			CFG_INVERT_POLARITY: invert = val[0];
			default: ;
		endcase
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic note_mismatch(input string field, input logic [7:0] want, input logic [7:0] got);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
		end
	endtask

	// Receiver stall: a style picked anew whenever its random run ends, one of them never stalling.
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_left == 0) begin
			stall_style <= 2'($urandom_range(0, 3));
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 2) == 0);
			2'd2: out_stall <= ((stall_phase % 7) < 3);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pin_levels_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS) begin
					$display("%0t ns: unexpected result, expected none, got 0x%0h", $time, out_data);
				end
			end else begin
				expected_pins = pin_levels_q.pop_front();
				if (out_data.segment_lines !== expected_pins.segment_lines)
					note_mismatch("segment_lines", expected_pins.segment_lines,
						out_data.segment_lines);
				if (out_data.digit_enables !== expected_pins.digit_enables)
					note_mismatch("digit_enables", 8'(expected_pins.digit_enables),
						8'(out_data.digit_enables));
				if (out_data.colon_pin !== expected_pins.colon_pin)
					note_mismatch("colon_pin", 8'(expected_pins.colon_pin), 8'(out_data.colon_pin));
				if (out_data.beeper_pin !== expected_pins.beeper_pin)
					note_mismatch("beeper_pin", 8'(expected_pins.beeper_pin),
						8'(out_data.beeper_pin));
				if (out_data.scan_sync !== expected_pins.scan_sync)
					note_mismatch("scan_sync", 8'(expected_pins.scan_sync), 8'(out_data.scan_sync));
			end
		end
	end

	// Stimulus: script, register phases with random sequences, then short soaks.
	initial begin : stimulus
		logic [7:0] dim_val;
		logic [7:0] bright_val;
		logic       inv_val;
		int         sent;
		int         run;
		in_item_t   soak_load;

		dim_lvl = 8'd40;
		bright_lvl = 8'd0;
		invert = 1'b1;
		scan_idx = '0;
		blank_cnt = '0;
		blink_cnt = '0;
		beep_cnt = '0;
		zoom_lvl = '0;
		zoom_pre = '0;
		zoom_down = 1'b0;
		for (int i = 0; i < 4; i++) begin
			digits[i] = BLANK_CODE;
		end
		disp_mode = MODE_BRIGHT;
		colon_en = 1'b0;
		beep_mode = BEEP_MODE_OFF;
		seg_q = 8'hFF;
		en_q = 4'hF;
		colon_q = 1'b0;
		beep_q = 1'b0;
		sync_q = 1'b0;

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			send_item(SCRIPT[i].item, SCRIPT[i].typed, SCRIPT[i].want);
		end

		// Register phases: the extremes first, then random settings.
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			case (p)
				0: begin
					dim_val = 8'd0;
					bright_val = 8'd0;
					inv_val = 1'b0;
				end
				1: begin
					dim_val = 8'd255;
					bright_val = 8'd255;
					inv_val = 1'b1;
				end
				2: begin
					dim_val = DIM_DARK;
					bright_val = 8'd3;
					inv_val = 1'b0;
				end
				3: begin
					dim_val = DIM_DARK - 8'd1;
					bright_val = 8'd1;
					inv_val = 1'b1;
				end
				default: begin
					dim_val = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
					bright_val = ($urandom_range(0, 2) == 0) ? 8'($urandom)
						: 8'($urandom_range(0, 6));
					inv_val = 1'($urandom);
				end
			endcase
			write_reg(CFG_DIM_LEVEL, dim_val);
			write_reg(CFG_BRIGHT_LEVEL, bright_val);
			write_reg(CFG_INVERT_POLARITY, {7'($urandom), inv_val});
			if (p == 2) begin
				write_reg(CFG_UNUSED_INDEX, 8'($urandom));
			end

			// A load followed by a run of ticks; now and then loads back to back.
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				send_item(random_load(), 1'b0, NO_CHECK);
				sent++;
				if ($urandom_range(0, 5) != 0) begin
					run = ($urandom_range(0, 7) == 0) ? 300 : int'($urandom_range(1, 40));
					if (run > PHASE_ITEMS - sent) begin
						run = PHASE_ITEMS - sent;
					end
					repeat (run) send_item(random_tick(), 1'b0, NO_CHECK);
					sent += run;
				end
			end
		end

		// Short soaks in flash and zoom mode with the beeper in burst mode.
		drain_results();
		write_reg(CFG_DIM_LEVEL, 8'd30);
		write_reg(CFG_BRIGHT_LEVEL, 8'd2);
		write_reg(CFG_INVERT_POLARITY, 8'($urandom));
		soak_load = random_load();
		soak_load.display_mode = MODE_FLASH;
		soak_load.buzzer_mode = BEEP_MODE_BURST;
		send_item(soak_load, 1'b0, NO_CHECK);
		repeat (FLASH_SOAK) send_item(random_tick(), 1'b0, NO_CHECK);
		drain_results();
		soak_load.display_mode = MODE_ZOOM;
		send_item(soak_load, 1'b0, NO_CHECK);
		repeat (ZOOM_SOAK) send_item(random_tick(), 1'b0, NO_CHECK);

		drain_results();
		if (fail_count == 0) begin
			$display("** seven_segment_scan_driver_core: PASSED **");
		end else begin
			$display("** seven_segment_scan_driver_core: FAILED **");
		end
		$finish;
	end

	// Run limit, far above the slowest correct run of about 0.1 ms.
	initial begin
		#20_000_000;
		$display("** seven_segment_scan_driver_core: FAILED **");
		$finish;
	end

endmodule
